### hw/rtl/letter_ngram_histogram_defines.svh
// Assertion macros for the letter n-gram histogram.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef LETTER_NGRAM_HISTOGRAM_DEFINES_SVH
`define LETTER_NGRAM_HISTOGRAM_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, off during reset
`define LNH_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lnh: same-cycle check failed");
// next-cycle implication, off during reset
`define LNH_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lnh: next-cycle check failed");
`else
`define LNH_ASSERT_IMP(name, ante, cons)
`define LNH_ASSERT_NXT(name, ante, cons)
`endif
`endif

### hw/rtl/lnh_pkg.sv
// Shared types and constants of the letter n-gram histogram.
// No dependencies.
package lnh_pkg;

  localparam int SYMS    = 27;
  localparam int PAIRS   = SYMS * SYMS;
  localparam int TRIPLES = SYMS * SYMS * SYMS;
  localparam int PAIR_AW = 10;
  localparam int TRIP_AW = 15;
  localparam int OUT_W   = 32;
  localparam int CNT_W_DEF = 32;

  // op queue and result queue sizes (powers of two)
  localparam int OPQ_DEPTH  = 4;
  localparam int OPQ_AW     = 2;
  localparam int OPQ_CW     = 3;
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_AW    = 2;
  localparam int OUTQ_CW    = 3;

  // item kinds
  localparam logic [1:0] KIND_TEXT    = 2'd0;
  localparam logic [1:0] KIND_EOT     = 2'd1;
  localparam logic [1:0] KIND_RD_PAIR = 2'd2;
  localparam logic [1:0] KIND_RD_TRIP = 2'd3;

  localparam logic [4:0] SYM_MARK = 5'd0;

  // work handed from the front end to the count stores
  typedef struct packed {
    logic               upd_pair;
    logic               upd_trip;
    logic               is_read;
    logic               rd_trip;
    logic               rd_zero;
    logic [PAIR_AW-1:0] pair_idx;
    logic [TRIP_AW-1:0] trip_idx;
  } lnh_op_t;

  // back end status seen by the top level
  typedef struct packed {
    logic clr_busy;
    logic out_push;
    logic out_pop;
    logic out_full;
  } lnh_stat_t;

endpackage

### hw/rtl/lnh_in_if.sv
// Input channel: valid/ready handshake with one text or query word.
// Depends on lnh_pkg.
interface lnh_in_if import lnh_pkg::*;;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [7:0]         char_code;
  logic [TRIP_AW-1:0] query_index;

  modport source (output valid, kind, char_code, query_index, input ready);
  modport sink (input valid, kind, char_code, query_index, output ready);
endinterface

### hw/rtl/lnh_out_if.sv
// Result channel: valid/ready handshake with one count word.
// Depends on lnh_pkg.
interface lnh_out_if import lnh_pkg::*;;
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] count;

  modport source (output valid, count, input ready);
  modport sink (input valid, count, output ready);
endinterface

### hw/rtl/lnh_op_fifo.sv
// Small queue of decoded ops between the front end and the count stores.
// Depends on lnh_pkg.
module lnh_op_fifo import lnh_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  lnh_op_t push_op,
  input  logic    pop,
  output lnh_op_t head,
  output logic    full,
  output logic    empty
);

  lnh_op_t             slot_r [OPQ_DEPTH];
  logic [OPQ_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [OPQ_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [OPQ_CW-1:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == OPQ_CW'(OPQ_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = slot_r[rd_ptr_r];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + OPQ_CW'(push) - OPQ_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

### hw/rtl/lnh_front.sv
// Front end: folds and classifies text bytes, tracks the open word and
// turns each word into store ops. Depends on lnh_pkg and lnh_in_if.
module lnh_front import lnh_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  lnh_in_if.sink  in_ch,
  input  logic    q_full,
  input  logic    clr_busy,
  output logic    op_push,
  output lnh_op_t op
);

  logic [4:0] older_r, older_nxt;
  logic [4:0] newer_r, newer_nxt;
  logic [1:0] seen_r, seen_nxt;

  logic               accept;
  logic               is_upper, is_lower, is_ws;
  logic               letter, close_wd;
  logic [4:0]         sym, new_sym;
  logic [PAIR_AW-1:0] pair_idx;
  logic [TRIP_AW-1:0] trip_idx;

  assign in_ch.ready = !q_full && !clr_busy;
  assign accept      = in_ch.valid && in_ch.ready;

  // byte classes
  always_comb begin
    is_upper = (in_ch.char_code >= 8'h41) && (in_ch.char_code <= 8'h5A);
    is_lower = (in_ch.char_code >= 8'h61) && (in_ch.char_code <= 8'h7A);
    is_ws    = (in_ch.char_code == 8'h20) ||
               ((in_ch.char_code >= 8'h09) && (in_ch.char_code <= 8'h0D));
    sym      = is_upper ? 5'(in_ch.char_code - 8'h40) : 5'(in_ch.char_code - 8'h60);
  end

  // decode the word into an op
  always_comb begin
    letter   = 1'b0;
    close_wd = 1'b0;
    op       = '0;
    unique case (in_ch.kind) inside
      KIND_TEXT: begin
        letter   = is_upper || is_lower;
        close_wd = is_ws && (seen_r != 2'd0);
      end
      KIND_EOT: begin
        close_wd = (seen_r != 2'd0);
      end
      KIND_RD_PAIR, KIND_RD_TRIP: begin
        op.is_read = 1'b1;
        op.rd_trip = (in_ch.kind == KIND_RD_TRIP);
      end
      default: ;
    endcase

    new_sym  = letter ? sym : SYM_MARK;
    pair_idx = PAIR_AW'(newer_r) * PAIR_AW'(SYMS) + PAIR_AW'(new_sym);
    trip_idx = TRIP_AW'(older_r) * TRIP_AW'(PAIRS) + TRIP_AW'(pair_idx);

    if (op.is_read) begin
      // out-of-range queries read entry zero and return zero
      op.rd_zero  = op.rd_trip ? (in_ch.query_index >= TRIP_AW'(TRIPLES))
                               : (in_ch.query_index >= TRIP_AW'(PAIRS));
      op.pair_idx = op.rd_zero ? '0 : in_ch.query_index[PAIR_AW-1:0];
      op.trip_idx = op.rd_zero ? '0 : in_ch.query_index;
    end else begin
      op.upd_pair = letter || close_wd;
      op.upd_trip = close_wd || (letter && (seen_r != 2'd0));
      op.pair_idx = pair_idx;
      op.trip_idx = trip_idx;
    end

    op_push = accept && (op.upd_pair || op.is_read);
  end

  // open-word state
  always_comb begin
    older_nxt = older_r;
    newer_nxt = newer_r;
    seen_nxt  = seen_r;
    if (accept && letter) begin
      older_nxt = newer_r;
      newer_nxt = sym;
      seen_nxt  = (seen_r == 2'd2) ? 2'd2 : seen_r + 2'd1;
    end else if (accept && close_wd) begin
      older_nxt = SYM_MARK;
      newer_nxt = SYM_MARK;
      seen_nxt  = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      older_r <= SYM_MARK;
      newer_r <= SYM_MARK;
      seen_r  <= 2'd0;
    end else begin
      older_r <= older_nxt;
      newer_r <= newer_nxt;
      seen_r  <= seen_nxt;
    end
  end

endmodule

### hw/rtl/lnh_back.sv
// Back end: pair and triple count stores with read-modify-write,
// write-back forwarding, clearing pass and result queue.
// Depends on lnh_pkg and lnh_out_if.
module lnh_back import lnh_pkg::*; #(
  parameter int COUNT_WIDTH = CNT_W_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      op_valid,
  input  lnh_op_t   op,
  output logic      op_pop,
  lnh_out_if.source out_ch,
  output lnh_stat_t stat
);

  // count stores
  logic [COUNT_WIDTH-1:0] pair_mem [PAIRS];
  logic [COUNT_WIDTH-1:0] trip_mem [TRIPLES];

  logic               clr_busy_r;
  logic [TRIP_AW-1:0] clr_cnt_r;

  logic    s1_v_r;
  lnh_op_t s1_op_r;
  logic [COUNT_WIDTH-1:0] pair_rd_r, trip_rd_r;

  logic                   pair_wb_v_r, trip_wb_v_r;
  logic [PAIR_AW-1:0]     pair_wb_a_r;
  logic [TRIP_AW-1:0]     trip_wb_a_r;
  logic [COUNT_WIDTH-1:0] pair_wb_d_r, trip_wb_d_r;

  logic                   pair_we, trip_we;
  logic [PAIR_AW-1:0]     pair_wa;
  logic [TRIP_AW-1:0]     trip_wa;
  logic [COUNT_WIDTH-1:0] pair_wd, trip_wd;
  logic [COUNT_WIDTH-1:0] pair_cur, trip_cur, pair_inc, trip_inc, rd_cur;
  logic [OUT_W-1:0]       rd_clamp, rd_word;

  logic [OUT_W-1:0]   outq_r [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0] oq_wr_r, oq_rd_r;
  logic [OUTQ_CW-1:0] oq_cnt_r;
  logic               out_push, out_pop, credit_ok;

  // issue: a read needs a free result slot counting the one in flight
  assign credit_ok = (OUTQ_CW'(oq_cnt_r) + OUTQ_CW'(s1_v_r && s1_op_r.is_read))
                     < OUTQ_CW'(OUTQ_DEPTH);
  assign op_pop    = op_valid && !clr_busy_r && (!op.is_read || credit_ok);

  // clearing pass after reset, one entry of each store per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == TRIP_AW'(TRIPLES - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // update stage: take newest value, forwarding last write
  always_comb begin
    pair_cur = (pair_wb_v_r && (pair_wb_a_r == s1_op_r.pair_idx)) ? pair_wb_d_r : pair_rd_r;
    trip_cur = (trip_wb_v_r && (trip_wb_a_r == s1_op_r.trip_idx)) ? trip_wb_d_r : trip_rd_r;
    pair_inc = (&pair_cur) ? pair_cur : pair_cur + COUNT_WIDTH'(1);
    trip_inc = (&trip_cur) ? trip_cur : trip_cur + COUNT_WIDTH'(1);

    pair_we = clr_busy_r ? (clr_cnt_r < TRIP_AW'(PAIRS)) : (s1_v_r && s1_op_r.upd_pair);
    pair_wa = clr_busy_r ? clr_cnt_r[PAIR_AW-1:0] : s1_op_r.pair_idx;
    pair_wd = clr_busy_r ? '0 : pair_inc;
    trip_we = clr_busy_r || (s1_v_r && s1_op_r.upd_trip);
    trip_wa = clr_busy_r ? clr_cnt_r : s1_op_r.trip_idx;
    trip_wd = clr_busy_r ? '0 : trip_inc;
  end

  // store ports: one write, one registered read each
  always_ff @(posedge clk) begin
    if (pair_we) begin
      pair_mem[pair_wa] <= pair_wd;
    end
    pair_rd_r <= pair_mem[op.pair_idx];
  end

  always_ff @(posedge clk) begin
    if (trip_we) begin
      trip_mem[trip_wa] <= trip_wd;
    end
    trip_rd_r <= trip_mem[op.trip_idx];
  end

  // stage and write-back registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      pair_wb_v_r <= 1'b0;
      trip_wb_v_r <= 1'b0;
    end else begin
      s1_v_r      <= op_pop;
      pair_wb_v_r <= pair_we;
      trip_wb_v_r <= trip_we;
    end
  end

  always_ff @(posedge clk) begin
    s1_op_r     <= op;
    pair_wb_a_r <= pair_wa;
    pair_wb_d_r <= pair_wd;
    trip_wb_a_r <= trip_wa;
    trip_wb_d_r <= trip_wd;
  end

  // read result, clamped to the output word
  assign rd_cur = s1_op_r.rd_trip ? trip_cur : pair_cur;

  generate
    if (COUNT_WIDTH > OUT_W) begin : g_clamp
      assign rd_clamp = (|rd_cur[COUNT_WIDTH-1:OUT_W]) ? '1 : rd_cur[OUT_W-1:0];
    end else begin : g_extend
      assign rd_clamp = OUT_W'(rd_cur);
    end
  endgenerate

  assign rd_word  = s1_op_r.rd_zero ? '0 : rd_clamp;
  assign out_push = s1_v_r && s1_op_r.is_read;

  // result queue
  assign out_ch.valid = (oq_cnt_r != '0);
  assign out_ch.count = outq_r[oq_rd_r];
  assign out_pop      = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      if (out_push) begin
        oq_wr_r <= oq_wr_r + 1'b1;
      end
      if (out_pop) begin
        oq_rd_r <= oq_rd_r + 1'b1;
      end
      oq_cnt_r <= oq_cnt_r + OUTQ_CW'(out_push) - OUTQ_CW'(out_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (out_push) begin
      outq_r[oq_wr_r] <= rd_word;
    end
  end

  assign stat.clr_busy = clr_busy_r;
  assign stat.out_push = out_push;
  assign stat.out_pop  = out_pop;
  assign stat.out_full = (oq_cnt_r == OUTQ_CW'(OUTQ_DEPTH));

endmodule

### hw/rtl/letter_ngram_histogram.sv
// Letter bigram/trigram histogram, top level.
// Depends on lnh_pkg, lnh_in_if, lnh_out_if, lnh_front, lnh_op_fifo, lnh_back.
//
// Takes one word per cycle on in_chan while its ready is high: text bytes
// (letters folded to lower case, whitespace closes a word, other bytes
// ignored), end of text, and pair or triple count queries. Each letter or
// word end turns into at most one pair and one triple increment, which the
// two count stores (729 and 19683 entries, COUNT_WIDTH bits, saturating)
// apply as a read-modify-write with forwarding, so back-to-back hits on one
// entry still count right and the block sustains one word per cycle unless
// queries wait for result queue room. Query counts reach out_chan via the op
// queue, store read stage and result queue, and always see every update
// accepted before them; counts above 32 bits read as all ones. After reset a
// clearing pass zeroes both stores, and in_chan.ready stays low until done.
`include "letter_ngram_histogram_defines.svh"
module letter_ngram_histogram import lnh_pkg::*; #(
  parameter int COUNT_WIDTH = CNT_W_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  lnh_in_if.sink    in_chan,
  lnh_out_if.source out_chan
);

  logic      op_push, op_pop;
  logic      q_full, q_empty;
  lnh_op_t   push_op, head_op;
  lnh_stat_t stat;

  lnh_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_chan),
    .q_full   (q_full),
    .clr_busy (stat.clr_busy),
    .op_push  (op_push),
    .op       (push_op)
  );

  lnh_op_fifo u_opq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (op_push),
    .push_op (push_op),
    .pop     (op_pop),
    .head    (head_op),
    .full    (q_full),
    .empty   (q_empty)
  );

  lnh_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_valid (!q_empty),
    .op       (head_op),
    .op_pop   (op_pop),
    .out_ch   (out_chan),
    .stat     (stat)
  );

  // checks
  `LNH_ASSERT_IMP(a_clr_blocks_in, stat.clr_busy, !in_chan.ready)
  `LNH_ASSERT_IMP(a_opq_no_ovf, op_push, !q_full)
  `LNH_ASSERT_IMP(a_outq_no_ovf, stat.out_push && !stat.out_pop, !stat.out_full)
  `LNH_ASSERT_NXT(a_opq_fill, op_push && !op_pop, !q_empty)

endmodule

### tb/tb_letter_ngram_histogram.sv
// Testbench for letter_ngram_histogram: drives text, end-of-text and count reads,
// predicts every count in a scoreboard class and checks each result word in order.
// Depends on lnh_pkg, lnh_in_if, lnh_out_if and the letter_ngram_histogram RTL.
`timescale 1ns / 100ps
module tb_letter_ngram_histogram;
  import lnh_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_WORDS = 1700;
  localparam int HOLD_AT      = 600;
  localparam int SETTLE       = 16;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_EVERY_THIRD} rx_mode_e;

  // Running bigram/trigram tallies and the counts still owed by the block
  class ngram_scoreboard;
    bit [OUT_W-1:0] pair_tally [PAIRS];
    bit [OUT_W-1:0] trio_tally [TRIPLES];
    bit [4:0]       sym_old = SYM_MARK;
    bit [4:0]       sym_new = SYM_MARK;
    int unsigned    word_len = 0;  // letters in the open word, stops at 2
    bit [OUT_W-1:0] due_counts [$];
    int unsigned    errors = 0;

    function void tally_pair(bit [4:0] a, bit [4:0] b);
      int unsigned idx;
      idx = a * SYMS + b;
      if (pair_tally[idx] != '1) pair_tally[idx]++;
    endfunction

    function void tally_trio(bit [4:0] a, bit [4:0] b, bit [4:0] c);
      int unsigned idx;
      idx = (a * SYMS + b) * SYMS + c;
      if (trio_tally[idx] != '1) trio_tally[idx]++;
    endfunction

    // word end: closing pair and triple, only if a word is open
    function void close_word();
      if (word_len == 0) return;
      tally_pair(sym_new, SYM_MARK);
      tally_trio(sym_old, sym_new, SYM_MARK);
      sym_old  = SYM_MARK;
      sym_new  = SYM_MARK;
      word_len = 0;
    endfunction

    function void take_letter(bit [4:0] s);
      tally_pair(sym_new, s);
      if (word_len >= 1) tally_trio(sym_old, sym_new, s);
      sym_old = sym_new;
      sym_new = s;
      if (word_len < 2) word_len++;
    endfunction

    // one accepted input word
    function void note_word(logic [1:0] kind, logic [7:0] ch, logic [TRIP_AW-1:0] q);
      case (kind)
        KIND_TEXT: begin
          if (ch >= "A" && ch <= "Z") take_letter(5'(ch - 8'h40));
          else if (ch >= "a" && ch <= "z") take_letter(5'(ch - 8'h60));
          else if (ch == 8'h20 || (ch >= 8'h09 && ch <= 8'h0D)) close_word();
        end
        KIND_EOT: close_word();
        KIND_RD_PAIR: begin
          if (q < PAIRS) due_counts.push_back(pair_tally[q]);
          else due_counts.push_back('0);
        end
        default: begin
          if (q < TRIPLES) due_counts.push_back(trio_tally[q]);
          else due_counts.push_back('0);
        end
      endcase
    endfunction

    // one accepted result word
    function void check_count(logic [OUT_W-1:0] got);
      bit [OUT_W-1:0] want;
      if (due_counts.size() == 0) begin
        $display("%0t: count word with none expected, expected none, got %0d", $time, got);
        errors++;
        return;
      end
      want = due_counts.pop_front();
      if (got !== want) begin
        $display("%0t: count mismatch, expected %0d, got %0d", $time, want, got);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return due_counts.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  lnh_in_if  in_chan ();
  lnh_out_if out_chan ();

  letter_ngram_histogram dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  ngram_scoreboard tally_sb = new();

  int unsigned burst_left    = 0;
  bit          no_gaps       = 1'b0;
  bit          draining      = 1'b0;
  int unsigned hold_requests = 0;
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;
  rx_mode_e    rx_mode       = RX_OPEN;
  int unsigned rx_mode_left  = 0;
  int unsigned rx_tick       = 0;
  int unsigned cycle_count   = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // input monitor feeds the predictor
  always @(posedge clk) begin
    if (rst_n && in_chan.valid && in_chan.ready)
      tally_sb.note_word(in_chan.kind, in_chan.char_code, in_chan.query_index);
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready)
      tally_sb.check_count(out_chan.count);
  end

  // receiver: long hold on request, always ready while draining, else a changing stall pattern
  always @(posedge clk) begin
    rx_tick++;
    if (hold_left > 0) begin
      hold_left--;
      out_chan.ready <= 1'b0;
    end else if (hold_requests != hold_served) begin
      hold_served++;
      hold_left = HOLD_CYCLES;
      out_chan.ready <= 1'b0;
    end else if (draining) begin
      out_chan.ready <= 1'b1;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = rx_mode_e'($urandom_range(0, 3));
        rx_mode_left = $urandom_range(20, 300);
      end else begin
        rx_mode_left--;
      end
      case (rx_mode)
        RX_OPEN:   out_chan.ready <= 1'b1;
        RX_COIN:   out_chan.ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_chan.ready <= ($urandom_range(0, 3) == 0);
        default:   out_chan.ready <= (rx_tick % 3 == 0);
      endcase
    end
  end

  // offer one word and wait for its handshake; idle gaps fall between bursts
  task automatic push_word(logic [1:0] kind, logic [7:0] ch, logic [TRIP_AW-1:0] q);
    int unsigned gap;
    if (burst_left == 0 && !no_gaps) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end else if (burst_left > 0) begin
      burst_left--;
    end
    in_chan.valid       <= 1'b1;
    in_chan.kind        <= kind;
    in_chan.char_code   <= ch;
    in_chan.query_index <= q;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  task automatic push_text(string s);
    foreach (s[i]) push_word(KIND_TEXT, s[i], '0);
  endtask

  // mostly a few letters so that counts pile up; sometimes any letter, either case
  function automatic logic [7:0] pick_letter();
    logic [7:0] sym;
    sym = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(1, 5)) : 8'($urandom_range(1, 26));
    return ($urandom_range(0, 1) ? 8'h40 : 8'h60) + sym;
  endfunction

  function automatic int unsigned pick_sym();
    return ($urandom_range(0, 4) != 0) ? $urandom_range(0, 5) : $urandom_range(0, 26);
  endfunction

  function automatic logic [TRIP_AW-1:0] pair_at(int unsigned a, int unsigned b);
    return TRIP_AW'(a * SYMS + b);
  endfunction

  function automatic logic [TRIP_AW-1:0] trio_at(int unsigned a, int unsigned b,
                                                 int unsigned c);
    return TRIP_AW'((a * SYMS + b) * SYMS + c);
  endfunction

  initial begin
    int unsigned counted;
    int unsigned pick;
    int unsigned ws;
    bit          held;
    counted = 0;
    held    = 1'b0;
    in_chan.valid       <= 1'b0;
    in_chan.kind        <= KIND_TEXT;
    in_chan.char_code   <= '0;
    in_chan.query_index <= '0;
    rst_n               <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: read of a cleared entry first
    push_word(KIND_RD_PAIR, '0, '0);
    // letter extremes in both cases, ignored bytes inside the word, space ends it
    push_word(KIND_TEXT, "A", '0);
    push_word(KIND_TEXT, "z", '0);
    push_word(KIND_TEXT, 8'h80, '0);
    push_word(KIND_TEXT, ".", '0);
    push_word(KIND_TEXT, "Z", '0);
    push_word(KIND_TEXT, 8'hFF, '0);
    push_word(KIND_TEXT, 8'h08, '0);
    push_word(KIND_TEXT, 8'h0E, '0);
    push_word(KIND_TEXT, "a", '0);
    push_word(KIND_TEXT, 8'h20, '0);
    // whitespace with no open word
    push_word(KIND_TEXT, 8'h0D, '0);
    // one-letter word closed by end of text, then end of text with nothing open
    push_word(KIND_TEXT, "q", '0);
    push_word(KIND_EOT, '0, '0);
    push_word(KIND_EOT, '0, '0);
    // reads: counted entries, index extremes, out of range
    push_word(KIND_RD_PAIR, '0, pair_at(0, 1));
    push_word(KIND_RD_PAIR, '0, pair_at(26, 26));
    push_word(KIND_RD_PAIR, '0, TRIP_AW'(PAIRS));
    push_word(KIND_RD_PAIR, '0, '1);
    push_word(KIND_RD_TRIP, '0, trio_at(0, 17, 0));
    push_word(KIND_RD_TRIP, '0, trio_at(1, 26, 26));
    push_word(KIND_RD_TRIP, '0, trio_at(26, 26, 26));
    push_word(KIND_RD_TRIP, '0, TRIP_AW'(TRIPLES));
    push_word(KIND_RD_TRIP, '0, '1);
    push_word(KIND_RD_TRIP, '0, '0);
    // back-to-back hits on one entry, read right behind them
    push_text("aaaa b");
    push_word(KIND_RD_PAIR, '0, pair_at(1, 1));
    push_word(KIND_RD_TRIP, '0, trio_at(1, 1, 1));

    // random: words with random content, some noise and stray reads
    while (counted < RANDOM_WORDS) begin
      if (counted == HOLD_AT && !held) begin
        // receiver stops for a long stretch while reads keep coming
        held = 1'b1;
        hold_requests++;
        no_gaps = 1'b1;
        repeat (40) push_word(KIND_RD_PAIR, '0, pair_at(pick_sym(), pick_sym()));
        no_gaps = 1'b0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        push_word(KIND_TEXT, pick_letter(), '0);
        counted++;
      end else if (pick < 62) begin
        ws = $urandom_range(0, 5);
        push_word(KIND_TEXT, (ws == 5) ? 8'h20 : 8'(8'h09 + ws), '0);
        counted++;
      end else if (pick < 68) begin
        push_word(KIND_TEXT, 8'($urandom_range(0, 255)), TRIP_AW'($urandom_range(0, 32767)));
        counted++;
      end else if (pick < 71) begin
        push_word(KIND_EOT, '0, '0);
        counted++;
      end else if (pick < 82) begin
        push_word(KIND_RD_PAIR, '0, pair_at(pick_sym(), pick_sym()));
        counted++;
      end else if (pick < 93) begin
        push_word(KIND_RD_TRIP, '0, trio_at(pick_sym(), pick_sym(), pick_sym()));
        counted++;
      end else begin
        push_word($urandom_range(0, 1) ? KIND_RD_PAIR : KIND_RD_TRIP, '0,
                  TRIP_AW'($urandom_range(0, 32767)));
        counted++;
      end
    end
    in_chan.valid <= 1'b0;

    // drain the outstanding counts, then let the pipeline settle
    draining = 1'b1;
    while (tally_sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (tally_sb.pending() != 0) begin
      $display("%0t: count words missing, expected %0d more, got none",
               $time, tally_sb.pending());
    end
    if (tally_sb.errors == 0 && tally_sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/lnh_pkg.sv
hw/rtl/lnh_in_if.sv
hw/rtl/lnh_out_if.sv
hw/rtl/lnh_op_fifo.sv
hw/rtl/lnh_front.sv
hw/rtl/lnh_back.sv
hw/rtl/letter_ngram_histogram.sv
tb/tb_letter_ngram_histogram.sv
